[hw/rtl/mpd_pkg.sv]
// ----------------------------------------------------------------------------
// mpd_pkg
// shared constants and types for the 3-d point set diameter block
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int IN_W            = 16;
    localparam int DIST_W          = 17;
    localparam int SQ_OUT_W        = 34;
    // queue depth, power of two
    localparam int FIFO_DEPTH      = 2;

    typedef struct packed {
        logic last;
        logic drop;
    } item_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WALK   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_ROOT   = 5'b10000
    } back_state_t;

endpackage

[hw/rtl/max_pairwise_distance_3d.sv]
// ----------------------------------------------------------------------------
// max_pairwise_distance_3d
// diameter of a 3-d point set: largest pairwise squared distance and its root
// back end: a stored point is compared with all earlier stored points before it is written
// the back end handles one point at a time; the queue takes new points while it is not full
// last point: once it is stored or dropped, the root of the maximum is taken and the result strobe follows
// reset: async, clears counters, maximum, flags and queue; point memory not cleared
// ----------------------------------------------------------------------------
module max_pairwise_distance_3d #(
    parameter int MAX_POINTS = mpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_x,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_y,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_z,
    input  logic                                  last_point,
    output logic                                  done,
    output logic [mpd_pkg::DIST_W-1:0]            max_distance,
    output logic [mpd_pkg::SQ_OUT_W-1:0]          max_distance_squared,
    output logic                                  points_dropped
);
    import mpd_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CTL_W = $bits(item_ctrl_t);
    localparam int Q_W   = CTL_W + IDX_W + 3 * COORD_BITS;

    logic                    push;
    item_ctrl_t              f_ctrl;
    logic [3*COORD_BITS-1:0] f_coords;
    logic [IDX_W-1:0]        f_index;
    logic [Q_W-1:0]          q_in;
    logic [Q_W-1:0]          q_out;
    logic                    q_empty;
    logic                    q_full;
    logic                    q_pop;
    item_ctrl_t              b_ctrl;
    logic [3*COORD_BITS-1:0] b_coords;
    logic [IDX_W-1:0]        b_index;

    assign busy = q_full;
    assign q_in = {f_ctrl, f_index, f_coords};
    assign {b_ctrl, b_index, b_coords} = q_out;

    mpd_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .full       (q_full),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .last_point (last_point),
        .push       (push),
        .ctrl       (f_ctrl),
        .coords     (f_coords),
        .index      (f_index)
    );

    mpd_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    mpd_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_empty              (q_empty),
        .q_ctrl               (b_ctrl),
        .q_coords             (b_coords),
        .q_index              (b_index),
        .q_pop                (q_pop),
        .done                 (done),
        .max_distance         (max_distance),
        .max_distance_squared (max_distance_squared),
        .points_dropped       (points_dropped)
    );

endmodule

[hw/rtl/mpd_front.sv]
// ----------------------------------------------------------------------------
// mpd_front
// accepts points, trims coordinates and tags each one as stored or dropped
// ----------------------------------------------------------------------------
module mpd_front #(
    parameter int MAX_POINTS = mpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  full,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_x,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_y,
    input  logic signed [mpd_pkg::IN_W-1:0]       coord_z,
    input  logic                                  last_point,
    output logic                                  push,
    output mpd_pkg::item_ctrl_t                   ctrl,
    output logic [3*COORD_BITS-1:0]               coords,
    output logic [$clog2(MAX_POINTS)-1:0]         index
);
    import mpd_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = (COORD_BITS > IN_W) ? COORD_BITS : IN_W;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
    logic             room;

    // raw field bits, only the low coordinate bits are kept
    assign ext_x = EXT_W'($unsigned(coord_x));
    assign ext_y = EXT_W'($unsigned(coord_y));
    assign ext_z = EXT_W'($unsigned(coord_z));

    assign room      = (cnt_reg != CNT_W'(MAX_POINTS));
    assign push      = start && !full;
    assign ctrl.last = last_point;
    assign ctrl.drop = !room;
    assign coords    = {ext_z[COORD_BITS-1:0], ext_y[COORD_BITS-1:0], ext_x[COORD_BITS-1:0]};
    assign index     = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (last_point)
                cnt_next = '0;
            else if (room)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

[hw/rtl/mpd_fifo.sv]
// ----------------------------------------------------------------------------
// mpd_fifo
// short queue between the front and back parts
// ----------------------------------------------------------------------------
module mpd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);
    import mpd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/mpd_isqrt.sv]
// ----------------------------------------------------------------------------
// mpd_isqrt
// floor integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module mpd_isqrt #(
    parameter int RAD_W = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);
    import mpd_pkg::*;

    localparam int RT_W  = RAD_W / 2;
    localparam int ITR_W = $clog2(RT_W);

    logic [RAD_W-1:0] rad_reg;
    logic [RT_W:0]    rem_reg;
    logic [RT_W-1:0]  root_reg;
    logic [ITR_W-1:0] iter_reg;
    logic             run_reg;
    logic             done_reg;
    logic [RT_W+1:0]  rem_sh;
    logic [RT_W+1:0]  trial;
    logic             fits;

    assign rem_sh = {rem_reg[RT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (RT_W + 1)'(rem_sh - trial);
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[RT_W:0];
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                iter_reg <= ITR_W'(RT_W - 1);
            end
            else if (run_reg)
            begin
                if (iter_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/mpd_back.sv]
// ----------------------------------------------------------------------------
// mpd_back
// walks the stored points, tracks the largest squared distance and reports
// ----------------------------------------------------------------------------
module mpd_back #(
    parameter int MAX_POINTS = mpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mpd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  mpd_pkg::item_ctrl_t                   q_ctrl,
    input  logic [3*COORD_BITS-1:0]               q_coords,
    input  logic [$clog2(MAX_POINTS)-1:0]         q_index,
    output logic                                  q_pop,
    output logic                                  done,
    output logic [mpd_pkg::DIST_W-1:0]            max_distance,
    output logic [mpd_pkg::SQ_OUT_W-1:0]          max_distance_squared,
    output logic                                  points_dropped
);
    import mpd_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int DIFF_W = C + 1;
    localparam int PROD_W = 2 * C + 1;
    localparam int SQ_W   = 2 * C + 2;
    localparam int RT_W   = SQ_W / 2;

    back_state_t state_reg;
    back_state_t state_next;

    logic [3*C-1:0]    mem [MAX_POINTS];
    logic [3*C-1:0]    cur_coords_reg;
    item_ctrl_t        cur_ctrl_reg;
    logic [IDX_W-1:0]  cur_index_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic [3*C-1:0]    rd_data_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [PROD_W-1:0] sq_x_reg;
    logic [PROD_W-1:0] sq_y_reg;
    logic [PROD_W-1:0] sq_z_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [SQ_W-1:0]   best_reg;
    logic              ovf_reg;
    logic              done_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [SQ_OUT_W-1:0] sq_out_reg;
    logic              drop_out_reg;

    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [DIFF_W-1:0]   dz;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic signed [2*DIFF_W-1:0] pz;
    logic              root_start;
    logic              root_done;
    logic [RT_W-1:0]   root_val;
    logic              mem_we;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we = (state_reg == ST_COMMIT);
    assign root_start = ((state_reg == ST_COMMIT) && cur_ctrl_reg.last)
                     || (q_pop && q_ctrl.drop && q_ctrl.last);

    assign done                 = done_reg;
    assign max_distance         = dist_reg;
    assign max_distance_squared = sq_out_reg;
    assign points_dropped       = drop_out_reg;

    // distance datapath
    assign dx = $signed({cur_coords_reg[C-1], cur_coords_reg[C-1:0]})
              - $signed({rd_data_reg[C-1], rd_data_reg[C-1:0]});
    assign dy = $signed({cur_coords_reg[2*C-1], cur_coords_reg[2*C-1:C]})
              - $signed({rd_data_reg[2*C-1], rd_data_reg[2*C-1:C]});
    assign dz = $signed({cur_coords_reg[3*C-1], cur_coords_reg[3*C-1:2*C]})
              - $signed({rd_data_reg[3*C-1], rd_data_reg[3*C-1:2*C]});
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    mpd_isqrt #(
        .RAD_W (SQ_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (best_reg),
        .done     (root_done),
        .root     (root_val)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_ctrl.drop)
                        state_next = q_ctrl.last ? ST_ROOT : ST_IDLE;
                    else if (q_index == '0)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (rd_addr_reg == IDX_W'(cur_index_reg - 1'b1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = cur_ctrl_reg.last ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // point memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK)
            rd_data_reg <= mem[rd_addr_reg];
        if (mem_we)
            mem[cur_index_reg] <= cur_coords_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_coords_reg <= q_coords;
            cur_index_reg  <= q_index;
        end
        sq_x_reg <= px[PROD_W-1:0];
        sq_y_reg <= py[PROD_W-1:0];
        sq_z_reg <= pz[PROD_W-1:0];
        sum_reg  <= SQ_W'(sq_x_reg) + SQ_W'(sq_y_reg) + SQ_W'(sq_z_reg);
        if (root_done)
        begin
            dist_reg     <= DIST_W'(root_val);
            sq_out_reg   <= SQ_OUT_W'(best_reg);
            drop_out_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_ctrl_reg <= '0;
            rd_addr_reg  <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_WALK);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            done_reg  <= root_done;
            if (q_pop)
            begin
                cur_ctrl_reg <= q_ctrl;
                rd_addr_reg  <= '0;
                if (q_ctrl.drop)
                    ovf_reg <= 1'b1;
            end
            if (state_reg == ST_WALK)
                rd_addr_reg <= rd_addr_reg + 1'b1;
            if (v3_reg && (sum_reg > best_reg))
                best_reg <= sum_reg;
            if (root_done)
            begin
                best_reg <= '0;
                ovf_reg  <= 1'b0;
            end
        end
    end

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (rd_addr_reg < cur_index_reg))
        else $error("walk address past stored points");

    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("point stored before distance pipe drained");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

endmodule
